### hdl/pct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pct_pkg: shared types and constants for the polygon convexity test
// Coordinate, edge and product widths, and the cross product job that the
// front end hands to the back end.
// ----------------------------------------------------------------------------
package pct_pkg;

  localparam int CoordWidth   = 16;
  localparam int EdgeWidth    = CoordWidth + 1;
  localparam int ProdWidth    = 2 * EdgeWidth;
  localparam int InDataWidth  = ((2 * CoordWidth + 7) / 8) * 8;
  localparam int OutDataWidth = 8;
  localparam int QueueDepth   = 4;
  localparam int QueueAw      = $clog2(QueueDepth);
  localparam int QueueCw      = $clog2(QueueDepth + 1);

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [EdgeWidth-1:0]  edge_t;
  typedef logic signed [ProdWidth-1:0]  prod_t;
  typedef logic [1:0]                   vcount_t;

  // vertex count saturates here; from this point every vertex is a compare
  localparam vcount_t VertexSat   = 2'd3;
  localparam vcount_t VertexFirst = 2'd0;
  localparam vcount_t VertexSecnd = 2'd1;
  localparam vcount_t VertexThird = 2'd2;

  // one job per vertex that needs a cross product or ends a polygon
  typedef struct packed {
    edge_t ax;       // previous edge
    edge_t ay;
    edge_t bx;       // current edge
    edge_t by;
    edge_t cx;       // closing edge, last vertex back to first
    edge_t cy;
    edge_t fx;       // first edge
    edge_t fy;
    logic  use_a;    // previous x current product is valid
    logic  set_ref;  // that product sets the reference sign
    logic  last;     // polygon ends with this job
    logic  too_few;  // polygon ended before its third vertex
  } job_t;

endpackage
`default_nettype wire

### hdl/pct_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pct_front: vertex front end
// Tracks first and previous vertex and edge, forms the edge pairs each vertex
// needs and pushes one job per vertex that yields products or ends a polygon.
// ----------------------------------------------------------------------------
module pct_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire pct_pkg::coord_t vx_i,
  input  wire pct_pkg::coord_t vy_i,
  input  wire logic            last_i,
  output logic                 push_o,
  output pct_pkg::job_t        job_o
);

  pct_pkg::coord_t  first_vx_q, first_vy_q, prev_vx_q, prev_vy_q;
  pct_pkg::edge_t   first_ex_q, first_ey_q, prev_ex_q, prev_ey_q;
  pct_pkg::vcount_t count_q, count_d;
  pct_pkg::edge_t   ex, ey;

  assign ex = pct_pkg::edge_t'(vx_i) - pct_pkg::edge_t'(prev_vx_q);
  assign ey = pct_pkg::edge_t'(vy_i) - pct_pkg::edge_t'(prev_vy_q);

  always_comb begin
    if (last_i) begin
      count_d = pct_pkg::VertexFirst;
    end else if (count_q == pct_pkg::VertexSat) begin
      count_d = pct_pkg::VertexSat;
    end else begin
      count_d = count_q + 2'd1;
    end
  end

  always_comb begin
    job_o.ax      = prev_ex_q;
    job_o.ay      = prev_ey_q;
    job_o.bx      = ex;
    job_o.by      = ey;
    job_o.cx      = pct_pkg::edge_t'(first_vx_q) - pct_pkg::edge_t'(vx_i);
    job_o.cy      = pct_pkg::edge_t'(first_vy_q) - pct_pkg::edge_t'(vy_i);
    job_o.fx      = first_ex_q;
    job_o.fy      = first_ey_q;
    job_o.use_a   = (count_q == pct_pkg::VertexThird) || (count_q == pct_pkg::VertexSat);
    job_o.set_ref = (count_q == pct_pkg::VertexThird);
    job_o.last    = last_i;
    job_o.too_few = (count_q == pct_pkg::VertexFirst) || (count_q == pct_pkg::VertexSecnd);
    push_o        = accept_i && (job_o.use_a || last_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= pct_pkg::VertexFirst;
      first_vx_q <= '0;
      first_vy_q <= '0;
      prev_vx_q  <= '0;
      prev_vy_q  <= '0;
      first_ex_q <= '0;
      first_ey_q <= '0;
      prev_ex_q  <= '0;
      prev_ey_q  <= '0;
    end else if (accept_i) begin
      count_q   <= count_d;
      prev_vx_q <= vx_i;
      prev_vy_q <= vy_i;
      if (count_q == pct_pkg::VertexFirst) begin
        first_vx_q <= vx_i;
        first_vy_q <= vy_i;
      end else begin
        prev_ex_q <= ex;
        prev_ey_q <= ey;
        if (count_q == pct_pkg::VertexSecnd) begin
          first_ex_q <= ex;
          first_ey_q <= ey;
        end
      end
    end
  end

endmodule
`default_nettype wire

### hdl/pct_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pct_queue: job queue
// Short first-in first-out store that decouples the front end from the
// cross product back end.
// ----------------------------------------------------------------------------
module pct_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire pct_pkg::job_t job_i,
  input  wire logic          pop_i,
  output logic               valid_o,
  output logic               full_o,
  output pct_pkg::job_t      job_o
);

  pct_pkg::job_t                  mem_q [pct_pkg::QueueDepth];
  logic [pct_pkg::QueueAw-1:0]    wr_ptr_q, rd_ptr_q;
  logic [pct_pkg::QueueCw-1:0]    count_q;
  logic                           do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == pct_pkg::QueueCw'(pct_pkg::QueueDepth));
  assign do_pop  = pop_i && valid_o;
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/pct_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pct_back: cross product back end
// Registers the edge products of a job, compares them for the signs of the
// prev x current, current x closing and closing x first products, keeps the
// reference sign and mismatch flag, and registers the verdict for output.
// ----------------------------------------------------------------------------
module pct_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  input  wire pct_pkg::job_t job_i,
  output logic               pop_o,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output logic               is_convex_o,
  output logic               too_few_o
);

  pct_pkg::prod_t pa_l_q, pa_r_q, pb_l_q, pb_r_q, pc_l_q, pc_r_q;
  logic           s1_valid_q;
  logic           use_a_q, set_ref_q, last_q, too_few_q;
  logic           ref_pos_q, ref_pos_d, mism_q, mism_d;
  logic           res_valid_q, is_convex_q, too_few_res_q;
  logic           adv, c_a, c_b, c_c, ref_now, mism_now;

  // the whole pipe moves whenever the output register is free or emptying
  assign adv   = !res_valid_q || res_ready_i;
  assign pop_o = adv && job_valid_i;

  assign c_a = pa_l_q > pa_r_q;
  assign c_b = pb_l_q > pb_r_q;
  assign c_c = pc_l_q > pc_r_q;

  always_comb begin
    ref_now  = ref_pos_q;
    mism_now = mism_q;
    if (use_a_q) begin
      if (set_ref_q) begin
        ref_now = c_a;
      end else if (c_a != ref_pos_q) begin
        mism_now = 1'b1;
      end
    end
    if (last_q && !too_few_q && ((c_b != ref_now) || (c_c != ref_now))) begin
      mism_now = 1'b1;
    end
    // drop the polygon state once its verdict is out
    ref_pos_d = last_q ? 1'b0 : ref_now;
    mism_d    = last_q ? 1'b0 : mism_now;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa_l_q    <= pct_pkg::prod_t'(job_i.ax) * pct_pkg::prod_t'(job_i.by);
      pa_r_q    <= pct_pkg::prod_t'(job_i.ay) * pct_pkg::prod_t'(job_i.bx);
      pb_l_q    <= pct_pkg::prod_t'(job_i.bx) * pct_pkg::prod_t'(job_i.cy);
      pb_r_q    <= pct_pkg::prod_t'(job_i.by) * pct_pkg::prod_t'(job_i.cx);
      pc_l_q    <= pct_pkg::prod_t'(job_i.cx) * pct_pkg::prod_t'(job_i.fy);
      pc_r_q    <= pct_pkg::prod_t'(job_i.cy) * pct_pkg::prod_t'(job_i.fx);
      use_a_q   <= job_i.use_a;
      set_ref_q <= job_i.set_ref;
      last_q    <= job_i.last;
      too_few_q <= job_i.too_few;
    end
    if (adv && s1_valid_q && last_q) begin
      is_convex_q   <= !too_few_q && !mism_now;
      too_few_res_q <= too_few_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      ref_pos_q   <= 1'b0;
      mism_q      <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= job_valid_i;
      res_valid_q <= s1_valid_q && last_q;
      if (s1_valid_q) begin
        ref_pos_q <= ref_pos_d;
        mism_q    <= mism_d;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign is_convex_o = is_convex_q;
  assign too_few_o   = too_few_res_q;

endmodule
`default_nettype wire

### hdl/polygon_convexity_test.sv
`default_nettype none
// A marked vertex passes the job queue, product registers and output register before its verdict shows.
// Throughput: one vertex per cycle; the job queue fills only while the output
// is stalled, and then input ready drops.
// Reset: asynchronous, active low; clears the vertex count, polygon sign state,
// queue and pipeline valids, so the first item after reset opens a polygon.
// ----------------------------------------------------------------------------
// polygon_convexity_test: cross product sign test on a vertex stream
// Front end forms edge pairs per vertex, a short queue carries jobs to a
// registered multiplier back end that decides convexity on the last vertex.
// ----------------------------------------------------------------------------
module polygon_convexity_test (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [15:0] vertex_x, [31:16] vertex_y
  input  wire logic [pct_pkg::InDataWidth-1:0]     s_axis_tdata,
  input  wire logic                                s_axis_tlast,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [0] is_convex, [1] too_few_vertices, [7:2] zero
  output logic [pct_pkg::OutDataWidth-1:0]         m_axis_tdata
);

  logic          accept, push, full, job_valid, pop, is_convex, too_few;
  pct_pkg::job_t front_job, queue_job;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  pct_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .vx_i     (pct_pkg::coord_t'(s_axis_tdata[pct_pkg::CoordWidth-1:0])),
    .vy_i     (pct_pkg::coord_t'(s_axis_tdata[2*pct_pkg::CoordWidth-1:pct_pkg::CoordWidth])),
    .last_i   (s_axis_tlast),
    .push_o   (push),
    .job_o    (front_job)
  );

  pct_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .pop_i   (pop),
    .valid_o (job_valid),
    .full_o  (full),
    .job_o   (queue_job)
  );

  pct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (queue_job),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .is_convex_o (is_convex),
    .too_few_o   (too_few)
  );

  assign m_axis_tdata = {(pct_pkg::OutDataWidth - 2)'(0), too_few, is_convex};

endmodule
`default_nettype wire
